>>> rtl/oal_pkg.sv
package oal_pkg;

  localparam int VALUE_BITS = 32;
  localparam int KIND_BITS  = 2;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_GET    = 2'd0,
    KIND_LOCATE = 2'd1,
    KIND_INSERT = 2'd2,
    KIND_DELETE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic get_en;
    logic locate_en;
    logic insert_en;
    logic delete_en;
  } cell_ctrl_t;

endpackage

>>> rtl/oal_cell.sv
module oal_cell #(
  parameter int CELL_INDEX = 0,
  parameter int POS_BITS   = 7,
  parameter int WORD_BITS  = 32
) (
  input  logic                 clk,
  input  oal_pkg::cell_ctrl_t  ctrl,
  input  logic [POS_BITS-1:0]  position,
  input  logic [POS_BITS-1:0]  count,
  input  logic [WORD_BITS-1:0] key,
  input  logic [WORD_BITS-1:0] left_data,
  input  logic [WORD_BITS-1:0] right_data,
  output logic [WORD_BITS-1:0] data,
  output logic                 hit
);
  import oal_pkg::*;

  localparam logic [POS_BITS-1:0] MY_POS = POS_BITS'(CELL_INDEX);

  logic below_count;
  logic at_pos;
  logic after_pos;
  logic [WORD_BITS-1:0] data_next;
  logic hit_next;

  assign below_count = MY_POS < count;
  assign at_pos      = MY_POS == position;
  assign after_pos   = MY_POS > position;

  always_comb begin
    data_next = data;
    if (ctrl.insert_en) begin
      if (at_pos) begin
        data_next = key;
      end else if (after_pos) begin
        data_next = left_data;
      end
    end else if (ctrl.delete_en) begin
      if (at_pos || after_pos) begin
        data_next = right_data;
      end
    end
  end

  assign hit_next = below_count &&
                    ((ctrl.get_en && at_pos) || (ctrl.locate_en && (data == key)));

  always_ff @(posedge clk) begin
    data <= data_next;
    if (ctrl.capture) begin
      hit <= hit_next;
    end
  end

endmodule

>>> rtl/ordered_array_list_top.sv
// Channel  Direction  Fields (tdata lowest bit up)                  tuser
// s_axis   in         position, value                               kind
// m_axis   out        ok, found_index, read_value, count            -
//
// One operation at a time: transfer in, evaluation in the cell row, then the
// result register holds until its transfer; the next operation is taken only after it.
// Insert and delete shift the cells from the position up in the accept cycle; get and
// locate latch per-cell hits, then a priority pick selects the lowest hit.
// rst clears the count and the control; cell contents stay until written.
module ordered_array_list_top #(
  parameter int CAPACITY  = 64,
  parameter int WORD_BITS = 32,
  localparam int POS_BITS = $clog2(CAPACITY + 1),
  localparam int IDX_BITS = $clog2(CAPACITY),
  localparam int IN_BITS  = POS_BITS + oal_pkg::VALUE_BITS,
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = 1 + IDX_BITS + oal_pkg::VALUE_BITS + POS_BITS,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [IN_W-1:0]               s_axis_tdata,   // position, value
  input  logic [oal_pkg::KIND_BITS-1:0] s_axis_tuser,   // kind
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [OUT_W-1:0]              m_axis_tdata    // ok, found_index, read_value, count
);
  import oal_pkg::*;

  state_t state, state_next;

  logic                         accept;
  kind_t                        kind;
  logic [POS_BITS-1:0]          position;
  logic signed [VALUE_BITS-1:0] value;
  logic [WORD_BITS-1:0]         key;
  logic [POS_BITS-1:0]          count;
  logic [POS_BITS-1:0]          count_next;
  logic                         insert_ok;
  logic                         delete_ok;
  cell_ctrl_t                   ctrl;

  kind_t                        kind_q;
  logic                         modify_ok;

  logic [WORD_BITS-1:0] cell_data  [CAPACITY];
  logic [WORD_BITS-1:0] left_data  [CAPACITY];
  logic [WORD_BITS-1:0] right_data [CAPACITY];
  logic [CAPACITY-1:0]  hits;
  logic [CAPACITY-1:0]  first_hit;

  logic [IDX_BITS-1:0]          pick_index;
  logic [WORD_BITS-1:0]         pick_word;
  logic                         res_ok_next;
  logic [IDX_BITS-1:0]          res_index_next;
  logic signed [VALUE_BITS-1:0] res_value_next;

  logic                         res_ok;
  logic [IDX_BITS-1:0]          res_index;
  logic signed [VALUE_BITS-1:0] res_value;
  logic [POS_BITS-1:0]          res_count;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign kind     = kind_t'(s_axis_tuser);
  assign position = s_axis_tdata[POS_BITS-1:0];
  assign value    = s_axis_tdata[POS_BITS +: VALUE_BITS];
  assign key      = WORD_BITS'(value);

  assign insert_ok = (count < POS_BITS'(CAPACITY)) && (position <= count);
  assign delete_ok = position < count;

  always_comb begin
    ctrl.capture   = accept;
    ctrl.get_en    = accept && (kind == KIND_GET);
    ctrl.locate_en = accept && (kind == KIND_LOCATE);
    ctrl.insert_en = accept && (kind == KIND_INSERT) && insert_ok;
    ctrl.delete_en = accept && (kind == KIND_DELETE) && delete_ok;
  end

  always_comb begin
    count_next = count;
    if (ctrl.insert_en) begin
      count_next = count + POS_BITS'(1);
    end else if (ctrl.delete_en) begin
      count_next = count - POS_BITS'(1);
    end
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == 0) begin : g_first
        assign left_data[g] = '0;
      end else begin : g_left
        assign left_data[g] = cell_data[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign right_data[g] = '0;
      end else begin : g_right
        assign right_data[g] = cell_data[g+1];
      end

      oal_cell #(
        .CELL_INDEX (g),
        .POS_BITS   (POS_BITS),
        .WORD_BITS  (WORD_BITS)
      ) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .position   (position),
        .count      (count),
        .key        (key),
        .left_data  (left_data[g]),
        .right_data (right_data[g]),
        .data       (cell_data[g]),
        .hit        (hits[g])
      );
    end
  endgenerate

  assign first_hit = hits & (~hits + CAPACITY'(1));

  always_comb begin
    pick_index = '0;
    pick_word  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first_hit[i]) begin
        pick_index = pick_index | IDX_BITS'(i);
        pick_word  = pick_word | cell_data[i];
      end
    end
  end

  always_comb begin
    res_ok_next    = modify_ok;
    res_index_next = '0;
    res_value_next = '0;
    unique case (kind_q)
      KIND_GET: begin
        res_ok_next    = |hits;
        res_value_next = VALUE_BITS'(signed'(pick_word));
      end
      KIND_LOCATE: begin
        res_ok_next    = |hits;
        res_index_next = pick_index;
      end
      KIND_INSERT, KIND_DELETE: begin
        res_ok_next = modify_ok;
      end
      default: begin
        res_ok_next = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_EVAL;
      ST_EVAL: state_next = ST_DONE;
      ST_DONE: if (m_axis_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    m_axis_tvalid = (state == ST_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q    <= kind;
      modify_ok <= ctrl.insert_en || ctrl.delete_en;
    end
    if (state == ST_EVAL) begin
      res_ok    <= res_ok_next;
      res_index <= res_index_next;
      res_value <= res_value_next;
      res_count <= count;
    end
  end

  assign m_axis_tdata = OUT_W'({res_count, res_value, res_index, res_ok});

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import oal_pkg::*;

  localparam int CAP        = 64;
  localparam int IN_W       = 40;
  localparam int OUT_W      = 48;
  localparam int QUIET_MAX  = 2000;
  localparam int PHASE_OPS  = 160;
  localparam int SETTLE     = 10;
  localparam int BIAS_GROW   = 0;
  localparam int BIAS_SHRINK = 1;
  localparam int BIAS_MIXED  = 2;

  typedef struct packed {
    logic               ok;
    logic [5:0]         found_index;
    logic signed [31:0] read_value;
    logic [6:0]         count;
  } list_result_t;

  typedef struct packed {
    kind_t        kind;
    logic [6:0]   position;
    logic [31:0]  value;
    bit           typed;
    list_result_t result;
  } list_op_t;

  localparam list_result_t NO_RESULT = '0;

  list_op_t directed_ops [25] = '{
    '{KIND_GET,    7'd0,  32'd0,        1'b1, '{1'b0, 6'd0, 32'sd0, 7'd0}},
    '{KIND_DELETE, 7'd0,  32'd0,        1'b1, '{1'b0, 6'd0, 32'sd0, 7'd0}},
    '{KIND_LOCATE, 7'd0,  32'd0,        1'b1, '{1'b0, 6'd0, 32'sd0, 7'd0}},
    '{KIND_INSERT, 7'd1,  32'd5,        1'b1, '{1'b0, 6'd0, 32'sd0, 7'd0}},
    '{KIND_INSERT, 7'd64, 32'd5,        1'b1, '{1'b0, 6'd0, 32'sd0, 7'd0}},
    '{KIND_INSERT, 7'd0,  32'h7FFFFFFF, 1'b1, '{1'b1, 6'd0, 32'sd0, 7'd1}},
    '{KIND_INSERT, 7'd1,  32'h80000000, 1'b1, '{1'b1, 6'd0, 32'sd0, 7'd2}},
    '{KIND_GET,    7'd1,  32'h0,        1'b1, '{1'b1, 6'd0, 32'sh80000000, 7'd2}},
    '{KIND_GET,    7'd0,  32'hFFFFFFFF, 1'b1, '{1'b1, 6'd0, 32'sh7FFFFFFF, 7'd2}},
    '{KIND_GET,    7'd2,  32'h0,        1'b1, '{1'b0, 6'd0, 32'sd0, 7'd2}},
    '{KIND_INSERT, 7'd0,  32'hFFFFFFFF, 1'b0, NO_RESULT},
    '{KIND_INSERT, 7'd1,  32'h00000000, 1'b0, NO_RESULT},
    '{KIND_INSERT, 7'd2,  32'hFFFFFFFF, 1'b0, NO_RESULT},
    '{KIND_LOCATE, 7'd64, 32'hFFFFFFFF, 1'b0, NO_RESULT},
    '{KIND_LOCATE, 7'd0,  32'h80000000, 1'b0, NO_RESULT},
    '{KIND_LOCATE, 7'd3,  32'h12345678, 1'b0, NO_RESULT},
    '{KIND_GET,    7'd64, 32'h0,        1'b0, NO_RESULT},
    '{KIND_DELETE, 7'd5,  32'h0,        1'b0, NO_RESULT},
    '{KIND_DELETE, 7'd0,  32'hAAAAAAAA, 1'b0, NO_RESULT},
    '{KIND_LOCATE, 7'd0,  32'hFFFFFFFF, 1'b0, NO_RESULT},
    '{KIND_DELETE, 7'd3,  32'h0,        1'b0, NO_RESULT},
    '{KIND_GET,    7'd2,  32'h0,        1'b0, NO_RESULT},
    '{KIND_DELETE, 7'd1,  32'h0,        1'b0, NO_RESULT},
    '{KIND_INSERT, 7'd2,  32'h55555555, 1'b0, NO_RESULT},
    '{KIND_GET,    7'd63, 32'h0,        1'b0, NO_RESULT}
  };

  logic             clk;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic [1:0]       s_axis_tuser = KIND_GET;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  ordered_array_list_top u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  logic signed [31:0] list_words [CAP];
  int                 list_len = 0;
  list_result_t       pending_results [$];
  bit                 typed_pending = 1'b0;
  list_result_t       typed_result = '0;

  int error_count   = 0;
  int checked_count = 0;
  int op_count [4]  = '{0, 0, 0, 0};
  int hit_count     = 0;
  int full_refusals = 0;
  int peak_len      = 0;
  int quiet_cycles  = 0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic list_result_t apply_list_op(kind_t kind, logic [6:0] pos,
                                                 logic signed [31:0] val);
    list_result_t r;
    r = '0;
    case (kind)
      KIND_GET: begin
        if (pos < list_len) begin
          r.ok = 1'b1;
          r.read_value = list_words[pos[5:0]];
        end
      end
      KIND_LOCATE: begin
        for (int i = 0; i < list_len; i++) begin
          if (!r.ok && list_words[i] == val) begin
            r.ok = 1'b1;
            r.found_index = 6'(i);
          end
        end
      end
      KIND_INSERT: begin
        if (list_len < CAP && pos <= list_len) begin
          for (int i = list_len; i > pos; i--) list_words[i] = list_words[i-1];
          list_words[pos[5:0]] = val;
          list_len++;
          r.ok = 1'b1;
        end
      end
      default: begin
        if (pos < list_len) begin
          for (int i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
          r.ok = 1'b1;
        end
      end
    endcase
    r.count = 7'(list_len);
    return r;
  endfunction

  list_result_t predicted, received, wanted;
  kind_t        seen_kind;

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        seen_kind = kind_t'(s_axis_tuser);
        predicted = apply_list_op(seen_kind, s_axis_tdata[6:0], s_axis_tdata[38:7]);
        pending_results.push_back(typed_pending ? typed_result : predicted);
        op_count[seen_kind]++;
        if (predicted.ok) hit_count++;
        if (seen_kind == KIND_INSERT && !predicted.ok && list_len == CAP) full_refusals++;
        if (list_len > peak_len) peak_len = list_len;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        received.ok          = m_axis_tdata[0];
        received.found_index = m_axis_tdata[6:1];
        received.read_value  = m_axis_tdata[38:7];
        received.count       = m_axis_tdata[45:39];
        if (pending_results.size() == 0) begin
          $error("result transfer with no operation pending");
          error_count++;
        end else begin
          wanted = pending_results.pop_front();
          checked_count++;
          if (received.ok !== wanted.ok) begin
            $error("ok: expected %0d, got %0d", wanted.ok, received.ok);
            error_count++;
          end
          if (received.found_index !== wanted.found_index) begin
            $error("found_index: expected %0d, got %0d",
                   wanted.found_index, received.found_index);
            error_count++;
          end
          if (received.read_value !== wanted.read_value) begin
            $error("read_value: expected %0d, got %0d",
                   wanted.read_value, received.read_value);
            error_count++;
          end
          if (received.count !== wanted.count) begin
            $error("count: expected %0d, got %0d", wanted.count, received.count);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else if (quiet_cycles >= QUIET_MAX) begin
      $display("Verification failed");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  int rx_mode      = 0;
  int rx_mode_left = 0;
  int rx_stall     = 0;
  bit rx_ready;

  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      = $urandom_range(0, 2);
      rx_mode_left = $urandom_range(50, 300);
    end else
      rx_mode_left--;
    case (rx_mode)
      0: rx_ready = 1'b1;
      1: rx_ready = ($urandom_range(0, 3) != 0);
      default: begin
        if (rx_stall > 0) begin
          rx_stall--;
          rx_ready = 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
          rx_stall = $urandom_range(1, 12);
          rx_ready = 1'b0;
        end else
          rx_ready = 1'b1;
      end
    endcase
    m_axis_tready <= rx_ready;
  end

  int  burst_left = 0;
  bit  gaps_on    = 1'b1;

  task automatic send_list_op(list_op_t op);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gaps_on) begin
        gap = $urandom_range(1, 8);
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, op.value, op.position};
    s_axis_tuser  <= op.kind;
    typed_pending <= op.typed;
    typed_result  <= op.result;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  function automatic list_op_t random_list_op(int bias);
    list_op_t op;
    int roll, pick;
    op = '0;
    roll = $urandom_range(0, 99);
    case (bias)
      BIAS_GROW:
        op.kind = roll < 65 ? KIND_INSERT : roll < 75 ? KIND_DELETE :
                  roll < 88 ? KIND_GET : KIND_LOCATE;
      BIAS_SHRINK:
        op.kind = roll < 60 ? KIND_DELETE : roll < 70 ? KIND_INSERT :
                  roll < 85 ? KIND_GET : KIND_LOCATE;
      default:
        op.kind = roll < 30 ? KIND_INSERT : roll < 55 ? KIND_DELETE :
                  roll < 80 ? KIND_GET : KIND_LOCATE;
    endcase
    if (op.kind == KIND_LOCATE || $urandom_range(0, 9) == 0)
      op.position = 7'($urandom_range(0, CAP));
    else if (op.kind == KIND_INSERT)
      op.position = 7'($urandom_range(0, list_len));
    else
      op.position = list_len > 0 ? 7'($urandom_range(0, list_len - 1)) : 7'd0;
    pick = $urandom_range(0, 9);
    if (list_len > 0 && (pick < 3 || (op.kind == KIND_LOCATE && pick < 6)))
      op.value = list_words[$urandom_range(0, list_len - 1)];
    else if (pick == 6)
      case ($urandom_range(0, 3))
        0: op.value = 32'h80000000;
        1: op.value = 32'h7FFFFFFF;
        2: op.value = 32'h00000000;
        default: op.value = 32'hFFFFFFFF;
      endcase
    else
      op.value = $urandom;
    return op;
  endfunction

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    int phase_bias [4];
    phase_bias = '{BIAS_GROW, BIAS_SHRINK, BIAS_GROW, BIAS_MIXED};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (directed_ops[i]) send_list_op(directed_ops[i]);
    for (int p = 0; p < 4; p++) begin
      s_axis_tvalid <= 1'b0;
      wait_drained();
      @(negedge clk);
      gaps_on    = (p != 0);
      burst_left = 0;
      for (int n = 0; n < PHASE_OPS; n++) send_list_op(random_list_op(phase_bias[p]));
    end
    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      error_count++;
    end
    $display("Ran %0d gets, %0d locates, %0d inserts, %0d deletes; %0d results checked",
             op_count[KIND_GET], op_count[KIND_LOCATE], op_count[KIND_INSERT],
             op_count[KIND_DELETE], checked_count);
    $display("%0d operations succeeded, list peaked at %0d, %0d inserts refused while full",
             hit_count, peak_len, full_refusals);
    if (error_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
